// File: rtl/motion_shock_event_tracker_macros.svh
// assertion macros shared by the motion shock event tracker rtl
// no dependencies; included by the files that carry assertions
`ifndef MOTION_SHOCK_EVENT_TRACKER_MACROS_SVH
`define MOTION_SHOCK_EVENT_TRACKER_MACROS_SVH

// generic form with explicit clock and active-low reset
`define MSET_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// shorthand on the standard clk_i / rst_ni pair
`define MSET_ASSERT_STD(name, prop, msg) \
  `MSET_ASSERT(name, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/mset_pkg.sv
// types, constants and helpers for the motion shock event tracker
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mset_pkg;

  localparam int unsigned COUNT_WIDTH  = 32;
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned TIME_WIDTH   = 32;
  localparam int unsigned CFG_WIDTH    = 16;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam logic [SAMPLE_WIDTH-1:0] GRAVITY_MG = SAMPLE_WIDTH'(1000);

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOTION_THR = 3'd0,
    CFG_SHOCK_THR  = 3'd1,
    CFG_SEVERE_THR = 3'd2,
    CFG_DROP_THR   = 3'd3,
    CFG_HIGH_G_THR = 3'd4,
    CFG_STOP_TIME  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] motion_thr;
    logic [CFG_WIDTH-1:0] shock_thr;
    logic [CFG_WIDTH-1:0] severe_thr;
    logic [CFG_WIDTH-1:0] drop_thr;
    logic [CFG_WIDTH-1:0] high_g_thr;
    logic [CFG_WIDTH-1:0] stop_time;
  } cfg_t;

  typedef struct packed {
    logic high_g;
    logic drop;
    logic severe;
    logic shock;
    logic motion;
  } flags_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] magnitude;
    logic [TIME_WIDTH-1:0]   timestamp;
  } in_beat_t;

  typedef struct packed {
    logic                    moving;
    logic [SAMPLE_WIDTH-1:0] deviation;
    logic [SAMPLE_WIDTH-1:0] peak_magnitude;
    logic [4:0]              event_flags;
    logic [TIME_WIDTH-1:0]   movement_duration;
    logic [COUNT_WIDTH-1:0]  move_entries;
    logic [COUNT_WIDTH-1:0]  shock_edges;
    logic [COUNT_WIDTH-1:0]  severe_count;
    logic [COUNT_WIDTH-1:0]  drop_edges;
    logic [COUNT_WIDTH-1:0]  high_g_count;
  } out_beat_t;

  // saturating increment
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] cnt,
                                                     input logic en);
    if (en && (cnt != {COUNT_WIDTH{1'b1}})) begin
      return cnt + COUNT_WIDTH'(1);
    end
    return cnt;
  endfunction

endpackage

// File: rtl/mset_eval.sv
// per-sample deviation and threshold flags
// depends on mset_pkg
`timescale 1ns / 1ps

module mset_eval import mset_pkg::*; (
  input  logic [SAMPLE_WIDTH-1:0] magnitude_i,
  input  cfg_t                    cfg_i,
  output logic [SAMPLE_WIDTH-1:0] deviation_o,
  output flags_t                  flags_o
);

  assign deviation_o = (magnitude_i >= GRAVITY_MG) ? (magnitude_i - GRAVITY_MG)
                                                  : (GRAVITY_MG - magnitude_i);

  always_comb begin
    flags_o.motion = deviation_o >= cfg_i.motion_thr;
    flags_o.shock  = magnitude_i >= cfg_i.shock_thr;
    flags_o.severe = magnitude_i >= cfg_i.severe_thr;
    flags_o.drop   = magnitude_i <= cfg_i.drop_thr;
    flags_o.high_g = magnitude_i >= cfg_i.high_g_thr;
  end

endmodule

// File: rtl/mset_track.sv
// still/moving machine, peak hold and saturating event counters
// depends on mset_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "motion_shock_event_tracker_macros.svh"

module mset_track import mset_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    upd_i,
  input  in_beat_t                beat_i,
  input  logic [SAMPLE_WIDTH-1:0] deviation_i,
  input  flags_t                  flags_i,
  input  logic [CFG_WIDTH-1:0]    stop_time_i,
  output out_beat_t               status_o
);

  logic                    moving_q, moving_d;
  logic                    quiet_on_q, quiet_on_d;
  logic [SAMPLE_WIDTH-1:0] peak_q, peak_d;
  logic [TIME_WIDTH-1:0]   move_start_q, move_start_d;
  logic [TIME_WIDTH-1:0]   quiet_start_q, quiet_start_d;
  logic [2:0]              last_q, last_d;
  logic [COUNT_WIDTH-1:0]  motion_cnt_q, motion_cnt_d;
  logic [COUNT_WIDTH-1:0]  shock_cnt_q, shock_cnt_d;
  logic [COUNT_WIDTH-1:0]  severe_cnt_q, severe_cnt_d;
  logic [COUNT_WIDTH-1:0]  drop_cnt_q, drop_cnt_d;
  logic [COUNT_WIDTH-1:0]  high_g_cnt_q, high_g_cnt_d;
  logic                    enter_move;
  logic [TIME_WIDTH-1:0]   quiet_elapsed;

  assign quiet_elapsed = beat_i.timestamp - quiet_start_q;

  always_comb begin
    moving_d      = moving_q;
    quiet_on_d    = quiet_on_q;
    move_start_d  = move_start_q;
    quiet_start_d = quiet_start_q;
    enter_move    = 1'b0;
    peak_d        = (beat_i.magnitude > peak_q) ? beat_i.magnitude : peak_q;

    if (flags_i.motion) begin
      if (!moving_q) begin
        moving_d     = 1'b1;
        move_start_d = beat_i.timestamp;
        enter_move   = 1'b1;
      end
      quiet_on_d = 1'b0;
    end else if (moving_q) begin
      // first quiet sample only arms the timer
      if (!quiet_on_q) begin
        quiet_start_d = beat_i.timestamp;
        quiet_on_d    = 1'b1;
      end else if (quiet_elapsed >= TIME_WIDTH'(stop_time_i)) begin
        moving_d   = 1'b0;
        quiet_on_d = 1'b0;
      end
    end

    motion_cnt_d = sat_inc(motion_cnt_q, enter_move);
    shock_cnt_d  = sat_inc(shock_cnt_q, flags_i.shock && !last_q[0]);
    severe_cnt_d = sat_inc(severe_cnt_q, flags_i.severe && !last_q[1]);
    drop_cnt_d   = sat_inc(drop_cnt_q, flags_i.drop && !last_q[2]);
    high_g_cnt_d = sat_inc(high_g_cnt_q, flags_i.high_g);
    last_d       = {flags_i.drop, flags_i.severe, flags_i.shock};
  end

  // status after this sample, taken by the result register
  always_comb begin
    status_o.moving            = moving_d;
    status_o.deviation         = deviation_i;
    status_o.peak_magnitude    = peak_d;
    status_o.event_flags       = flags_i;
    status_o.movement_duration = moving_d ? (beat_i.timestamp - move_start_d) : '0;
    status_o.move_entries      = motion_cnt_d;
    status_o.shock_edges       = shock_cnt_d;
    status_o.severe_count      = severe_cnt_d;
    status_o.drop_edges        = drop_cnt_d;
    status_o.high_g_count      = high_g_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moving_q      <= 1'b0;
      quiet_on_q    <= 1'b0;
      peak_q        <= '0;
      move_start_q  <= '0;
      quiet_start_q <= '0;
      last_q        <= '0;
      motion_cnt_q  <= '0;
      shock_cnt_q   <= '0;
      severe_cnt_q  <= '0;
      drop_cnt_q    <= '0;
      high_g_cnt_q  <= '0;
    end else if (upd_i) begin
      moving_q      <= moving_d;
      quiet_on_q    <= quiet_on_d;
      peak_q        <= peak_d;
      move_start_q  <= move_start_d;
      quiet_start_q <= quiet_start_d;
      last_q        <= last_d;
      motion_cnt_q  <= motion_cnt_d;
      shock_cnt_q   <= shock_cnt_d;
      severe_cnt_q  <= severe_cnt_d;
      drop_cnt_q    <= drop_cnt_d;
      high_g_cnt_q  <= high_g_cnt_d;
    end
  end

  `MSET_ASSERT_STD(a_peak_monotonic, 1'b1 |=> (peak_q >= $past(peak_q)), "peak decreased")
  `MSET_ASSERT_STD(a_still_no_timer, !moving_q |-> !quiet_on_q, "quiet timer armed while still")
  `MSET_ASSERT_STD(a_idle_holds, !upd_i |=> $stable(motion_cnt_q) && $stable(moving_q),
                   "state moved without a sample")

endmodule

// File: rtl/motion_shock_event_tracker.sv
// a sample beat passes the input register and then the result register before its status beat leaves
// throughput: one sample per cycle while out_stall_i is low; the only loop is the state/counter update in mset_track
// an output stall backs up into the input register, then into in_stall_o in the same cycle
// reset: asynchronous, active low; clears state, counters, valids, loads threshold defaults
// configuration registers are plain flops written through the cfg port, no read-back
`timescale 1ns / 1ps
`include "motion_shock_event_tracker_macros.svh"

module motion_shock_event_tracker import mset_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // sample channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_beat_t             in_data_i,
  // status channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_beat_t            out_data_o,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0] cfg_wdata_i
);

  cfg_t                    cfg_q;
  logic                    in_valid_q;
  in_beat_t                in_beat_q;
  logic                    out_valid_q;
  out_beat_t               out_beat_q;
  logic                    res_free;
  logic                    advance;
  logic [SAMPLE_WIDTH-1:0] deviation;
  flags_t                  flags;
  out_beat_t               status;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motion_thr <= CFG_WIDTH'(100);
      cfg_q.shock_thr  <= CFG_WIDTH'(2000);
      cfg_q.severe_thr <= CFG_WIDTH'(4000);
      cfg_q.drop_thr   <= CFG_WIDTH'(300);
      cfg_q.high_g_thr <= CFG_WIDTH'(1500);
      cfg_q.stop_time  <= CFG_WIDTH'(10);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MOTION_THR: cfg_q.motion_thr <= cfg_wdata_i;
        CFG_SHOCK_THR:  cfg_q.shock_thr  <= cfg_wdata_i;
        CFG_SEVERE_THR: cfg_q.severe_thr <= cfg_wdata_i;
        CFG_DROP_THR:   cfg_q.drop_thr   <= cfg_wdata_i;
        CFG_HIGH_G_THR: cfg_q.high_g_thr <= cfg_wdata_i;
        CFG_STOP_TIME:  cfg_q.stop_time  <= cfg_wdata_i;
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: the result register frees when empty or being taken, and
  // the input register moves forward whenever the result register is free
  // ---------------------------------------------------------------------------
  assign res_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && res_free;
  assign in_stall_o = in_valid_q && !res_free;

  // input register, loads a new beat whenever it is empty or draining
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_beat_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // per-sample logic between the two registers
  // ---------------------------------------------------------------------------
  mset_eval u_eval (
    .magnitude_i (in_beat_q.magnitude),
    .cfg_i       (cfg_q),
    .deviation_o (deviation),
    .flags_o     (flags)
  );

  // tracker state commits exactly when the status beat enters the result reg
  mset_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (advance),
    .beat_i      (in_beat_q),
    .deviation_i (deviation),
    .flags_i     (flags),
    .stop_time_i (cfg_q.stop_time),
    .status_o    (status)
  );

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_beat_q <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_beat_q;

  `MSET_ASSERT_STD(a_still_zero_dur,
                   out_valid_q && !out_beat_q.moving |-> out_beat_q.movement_duration == '0,
                   "nonzero duration while still")
  `MSET_ASSERT_STD(a_advance_fills, advance |=> out_valid_q, "advanced beat lost")
  `MSET_ASSERT_STD(a_stall_holds_input, in_stall_o |=> in_valid_q,
                   "input register emptied while stalled")

endmodule

// File: dv/mset_status_checker.sv
// status checker for the motion shock event tracker: watches the sample, status and config ports
// depends on mset_pkg for the beat and register types; instantiated by tb beside the block
`timescale 1ns / 1ps

module mset_status_checker import mset_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_beat_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_beat_t            out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0] cfg_wdata_i,
  output int                   mismatch_count_o,
  output int                   pending_o
);

  // threshold copy, follows every write seen on the config port
  cfg_t thr_cfg;

  // tracker state copy
  logic                    moving;
  logic [SAMPLE_WIDTH-1:0] peak;
  logic [TIME_WIDTH-1:0]   move_start;
  logic [TIME_WIDTH-1:0]   quiet_start;
  logic                    quiet_on;
  logic                    prev_shock;
  logic                    prev_severe;
  logic                    prev_drop;
  logic [COUNT_WIDTH-1:0]  motion_cnt;
  logic [COUNT_WIDTH-1:0]  shock_cnt;
  logic [COUNT_WIDTH-1:0]  severe_cnt;
  logic [COUNT_WIDTH-1:0]  drop_cnt;
  logic [COUNT_WIDTH-1:0]  high_g_cnt;

  out_beat_t expected_status_q[$];
  out_beat_t want_status;
  out_beat_t new_status;
  int        mismatches = 0;
  int        status_beats = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = expected_status_q.size();

  function automatic logic [COUNT_WIDTH-1:0] bump_count(input logic [COUNT_WIDTH-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("status beat %0d: %s is %0h, expected %0h",
                                status_beats, name, got, want));
  endtask

  // expected status for one sample, advances the state copy
  task automatic track_sample(input in_beat_t s, output out_beat_t st);
    logic [SAMPLE_WIDTH-1:0] dev;
    flags_t                  f;
    dev = (s.magnitude >= GRAVITY_MG) ? s.magnitude - GRAVITY_MG : GRAVITY_MG - s.magnitude;
    if (s.magnitude > peak) peak = s.magnitude;

    f.motion = dev >= thr_cfg.motion_thr;
    f.shock  = s.magnitude >= thr_cfg.shock_thr;
    f.severe = s.magnitude >= thr_cfg.severe_thr;
    f.drop   = s.magnitude <= thr_cfg.drop_thr;
    f.high_g = s.magnitude >= thr_cfg.high_g_thr;

    if (f.motion) begin
      if (!moving) begin
        moving     = 1'b1;
        move_start = s.timestamp;
        motion_cnt = bump_count(motion_cnt);
      end
      quiet_on = 1'b0;
    end else if (moving) begin
      // first quiet sample only arms the timer, even with a zero stop time
      if (!quiet_on) begin
        quiet_start = s.timestamp;
        quiet_on    = 1'b1;
      end else if (TIME_WIDTH'(s.timestamp - quiet_start) >= thr_cfg.stop_time) begin
        moving   = 1'b0;
        quiet_on = 1'b0;
      end
    end

    if (f.shock && !prev_shock)   shock_cnt  = bump_count(shock_cnt);
    if (f.severe && !prev_severe) severe_cnt = bump_count(severe_cnt);
    if (f.drop && !prev_drop)     drop_cnt   = bump_count(drop_cnt);
    if (f.high_g)                 high_g_cnt = bump_count(high_g_cnt);
    prev_shock  = f.shock;
    prev_severe = f.severe;
    prev_drop   = f.drop;

    st.moving            = moving;
    st.deviation         = dev;
    st.peak_magnitude    = peak;
    st.event_flags       = f;
    st.movement_duration = moving ? TIME_WIDTH'(s.timestamp - move_start) : '0;
    st.move_entries      = motion_cnt;
    st.shock_edges       = shock_cnt;
    st.severe_count      = severe_cnt;
    st.drop_edges        = drop_cnt;
    st.high_g_count      = high_g_cnt;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_cfg.motion_thr = CFG_WIDTH'(100);
      thr_cfg.shock_thr  = CFG_WIDTH'(2000);
      thr_cfg.severe_thr = CFG_WIDTH'(4000);
      thr_cfg.drop_thr   = CFG_WIDTH'(300);
      thr_cfg.high_g_thr = CFG_WIDTH'(1500);
      thr_cfg.stop_time  = CFG_WIDTH'(10);
      moving      = 1'b0;
      peak        = '0;
      move_start  = '0;
      quiet_start = '0;
      quiet_on    = 1'b0;
      prev_shock  = 1'b0;
      prev_severe = 1'b0;
      prev_drop   = 1'b0;
      motion_cnt  = '0;
      shock_cnt   = '0;
      severe_cnt  = '0;
      drop_cnt    = '0;
      high_g_cnt  = '0;
      expected_status_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MOTION_THR: thr_cfg.motion_thr = cfg_wdata_i;
          CFG_SHOCK_THR:  thr_cfg.shock_thr  = cfg_wdata_i;
          CFG_SEVERE_THR: thr_cfg.severe_thr = cfg_wdata_i;
          CFG_DROP_THR:   thr_cfg.drop_thr   = cfg_wdata_i;
          CFG_HIGH_G_THR: thr_cfg.high_g_thr = cfg_wdata_i;
          CFG_STOP_TIME:  thr_cfg.stop_time  = cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (expected_status_q.size() == 0) begin
          report_mismatch($sformatf("status beat %0d arrived with nothing expected",
                                    status_beats));
        end else begin
          want_status = expected_status_q.pop_front();
          check_field("moving", out_data_i.moving, want_status.moving);
          check_field("deviation", out_data_i.deviation, want_status.deviation);
          check_field("peak_magnitude", out_data_i.peak_magnitude,
                      want_status.peak_magnitude);
          check_field("event_flags", out_data_i.event_flags, want_status.event_flags);
          check_field("movement_duration", out_data_i.movement_duration,
                      want_status.movement_duration);
          check_field("move_entries", out_data_i.move_entries, want_status.move_entries);
          check_field("shock_edges", out_data_i.shock_edges, want_status.shock_edges);
          check_field("severe_count", out_data_i.severe_count, want_status.severe_count);
          check_field("drop_edges", out_data_i.drop_edges, want_status.drop_edges);
          check_field("high_g_count", out_data_i.high_g_count, want_status.high_g_count);
        end
        status_beats++;
      end

      if (in_valid_i && !in_stall_i) begin
        track_sample(in_data_i, new_status);
        expected_status_q.push_back(new_status);
      end
    end
  end

endmodule

// File: dv/tb.sv
// top of the motion shock event tracker testbench: clock, reset, sample and config stimulus
// depends on mset_pkg, the block and mset_status_checker, which predicts and compares
`timescale 1ns / 1ps

module tb;
  import mset_pkg::*;

  // cycles with no beat on either channel before the run is declared hung
  localparam int unsigned HANG_LIMIT = 5000;
  localparam int unsigned PHASE_SAMPLES = 275;

  // register indexes the block has no register for, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  // kind of sample run the random generator is in
  typedef enum logic [1:0] {
    MODE_REST,
    MODE_MOVE,
    MODE_EDGE,
    MODE_NOISE
  } run_mode_e;

  logic clk;
  logic rst_n = 1'b0;

  // every block input known from time zero
  logic                 in_valid  = 1'b0;
  in_beat_t             in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_WIDTH-1:0] cfg_wdata = '0;

  logic      in_stall;
  logic      out_valid;
  out_beat_t out_data;

  int mismatches;
  int pending;

  // random idling on both sides, cleared for the last phase
  logic idle_en = 1'b1;

  // stimulus shaping state
  cfg_t                  cur_cfg;
  run_mode_e             run_mode = MODE_REST;
  int                    run_left = 0;
  logic [TIME_WIDTH-1:0] stamp = '0;
  int unsigned           hang_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  motion_shock_event_tracker i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  mset_status_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // watchdog: any accepted beat on either channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  // status side: random stall bursts between free stretches
  initial begin
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  function automatic in_beat_t sample_beat(input int unsigned mag, input int unsigned ts);
    in_beat_t b;
    b.magnitude = SAMPLE_WIDTH'(mag);
    b.timestamp = TIME_WIDTH'(ts);
    return b;
  endfunction

  // present one beat (called at a clock edge), hold it until taken, then maybe go idle
  task automatic send_sample(input in_beat_t b);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // block must be idle before any register write
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // full register set, plus writes to the spare indexes that must change nothing
  task automatic program_cfg(input cfg_t c);
    write_reg(CFG_MOTION_THR, c.motion_thr);
    write_reg(CFG_IDX_SPARE_LO, CFG_WIDTH'($urandom));
    write_reg(CFG_SHOCK_THR, c.shock_thr);
    write_reg(CFG_SEVERE_THR, c.severe_thr);
    write_reg(CFG_DROP_THR, c.drop_thr);
    write_reg(CFG_HIGH_G_THR, c.high_g_thr);
    write_reg(CFG_IDX_SPARE_HI, CFG_WIDTH'($urandom));
    write_reg(CFG_STOP_TIME, c.stop_time);
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic cfg_t make_cfg(input int unsigned motion, input int unsigned shock,
                                    input int unsigned severe, input int unsigned drop,
                                    input int unsigned high_g, input int unsigned stop);
    cfg_t c;
    c.motion_thr = CFG_WIDTH'(motion);
    c.shock_thr  = CFG_WIDTH'(shock);
    c.severe_thr = CFG_WIDTH'(severe);
    c.drop_thr   = CFG_WIDTH'(drop);
    c.high_g_thr = CFG_WIDTH'(high_g);
    c.stop_time  = CFG_WIDTH'(stop);
    return c;
  endfunction

  // random samples in runs: rest near gravity, real motion, threshold edges, or pure noise
  task automatic make_sample(output in_beat_t b);
    int r;
    int m;
    int off;
    int thr;
    if (run_left == 0) begin
      r = $urandom_range(0, 99);
      run_mode = (r < 40) ? MODE_REST : (r < 70) ? MODE_MOVE : (r < 88) ? MODE_EDGE : MODE_NOISE;
      run_left = $urandom_range(3, 40);
      // now and then start a run just short of the timestamp wrap
      if ($urandom_range(0, 15) == 0) stamp = 32'hFFFF_FFFF - $urandom_range(0, 30);
    end
    run_left--;
    thr = cur_cfg.motion_thr;
    case (run_mode)
      MODE_REST: begin
        // deviation kept below a nonzero motion threshold so the quiet timer runs
        off = (thr == 0) ? 0 : $urandom_range(0, (thr > 1000) ? 1000 : thr - 1);
        m = $urandom_range(0, 1) ? 1000 + off : 1000 - off;
        stamp = stamp + TIME_WIDTH'($urandom_range(0, 3));
      end
      MODE_MOVE: begin
        off = $urandom_range(thr, thr + 600);
        m = $urandom_range(0, 1) ? 1000 + off : 1000 - off;
        stamp = stamp + TIME_WIDTH'($urandom_range(0, 2));
      end
      MODE_EDGE: begin
        case ($urandom_range(0, 4))
          0: off = cur_cfg.shock_thr;
          1: off = cur_cfg.severe_thr;
          2: off = cur_cfg.drop_thr;
          3: off = cur_cfg.high_g_thr;
          default: off = $urandom_range(0, 1) ? 1000 + thr : 1000 - thr;
        endcase
        m = off + $urandom_range(0, 4) - 2;
        stamp = stamp + TIME_WIDTH'(1);
      end
      default: begin
        m = $urandom_range(0, 65535);
        if ($urandom_range(0, 2) == 0) stamp = $urandom;
        else stamp = stamp + TIME_WIDTH'($urandom_range(0, 1 << 20));
      end
    endcase
    if (m < 0) m = 0;
    if (m > 65535) m = 65535;
    b.magnitude = SAMPLE_WIDTH'(m);
    b.timestamp = stamp;
  endtask

  initial begin
    cfg_t     phase_cfg[7];
    in_beat_t b;

    cur_cfg = make_cfg(100, 2000, 4000, 300, 1500, 10);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset thresholds
    send_sample(sample_beat(1000, 0));             // quiet while still, no timer
    send_sample(sample_beat(0, 1));                // deviation 1000, enter moving, drop
    send_sample(sample_beat(1050, 2));             // first quiet sample arms the timer
    send_sample(sample_beat(1099, 5));             // still inside stop time
    send_sample(sample_beat(1100, 6));             // deviation at threshold, timer stopped
    send_sample(sample_beat(900, 7));              // low side at threshold
    send_sample(sample_beat(901, 8));              // timer armed again
    send_sample(sample_beat(1000, 17));            // one short of stop time
    send_sample(sample_beat(1000, 18));            // stop time reached, back to still
    send_sample(sample_beat(65535, 19));           // full scale: every high flag, new peak
    send_sample(sample_beat(65535, 20));           // flags held, no new edges
    send_sample(sample_beat(1999, 21));            // just under shock
    send_sample(sample_beat(2000, 22));            // shock edge again
    send_sample(sample_beat(3999, 23));
    send_sample(sample_beat(4000, 24));            // severe edge again
    send_sample(sample_beat(1500, 25));            // high g at threshold
    send_sample(sample_beat(1499, 26));
    send_sample(sample_beat(300, 27));             // drop at threshold
    send_sample(sample_beat(301, 28));
    send_sample(sample_beat(300, 29));             // third drop edge
    send_sample(sample_beat(0, 32'hFFFF_FFFE));    // motion just before the wrap
    send_sample(sample_beat(1000, 32'hFFFF_FFFF)); // quiet timer armed at top of range
    send_sample(sample_beat(1000, 8));             // wrapped difference 9
    send_sample(sample_beat(1000, 9));             // wrapped difference 10, still

    // zero stop time: the machine still needs a second quiet sample to leave moving
    wait_drained();
    program_cfg(make_cfg(100, 2000, 4000, 300, 1500, 0));
    send_sample(sample_beat(0, 100));
    send_sample(sample_beat(1000, 100));
    send_sample(sample_beat(1000, 100));

    // random phases, extremes among them
    phase_cfg[0] = make_cfg(100, 2000, 4000, 300, 1500, 10);
    phase_cfg[1] = make_cfg(0, 0, 0, 0, 0, 0);
    phase_cfg[2] = make_cfg(65535, 65535, 65535, 65535, 65535, 65535);
    phase_cfg[3] = make_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 65535));
    phase_cfg[4] = make_cfg($urandom_range(0, 1500), $urandom_range(1000, 3000),
                            $urandom_range(2000, 6000), $urandom_range(0, 900),
                            $urandom_range(1000, 2500), $urandom_range(0, 20));
    phase_cfg[5] = make_cfg(50, 1800, 3000, 200, 1200, 3);
    phase_cfg[6] = make_cfg(100, 2000, 4000, 300, 1500, 0);

    for (int p = 0; p < 7; p++) begin
      wait_drained();
      program_cfg(phase_cfg[p]);
      // no idling at all in the last phase
      if (p == 6) idle_en = 1'b0;
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        make_sample(b);
        send_sample(b);
      end
    end

    // drain: every status beat in, then an idle tail to catch anything stray
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
